// File: hdl/mck_pkg.sv
// Shared types, constants and the character code table for the Morse keyer.
package mck_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned DotW  = 24;
  localparam int unsigned DurW  = 27;
  localparam int unsigned LenW  = 3;
  localparam int unsigned PatW  = 5;
  localparam int unsigned SegW  = LenW + 1;

  localparam logic [DotW-1:0] DOT_TICKS_RESET = DotW'(1000);

  // What a character turns into
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_MORSE,
    KIND_SLASH
  } kind_e;

  // Decoded character: symbol count and pattern, first symbol in the MSB, 1 = dash
  typedef struct packed {
    kind_e             kind;
    logic [LenW-1:0]   len;
    logic [PatW-1:0]   pat;
  } code_t;

  // One keying segment
  typedef struct packed {
    logic            led_on;
    logic [DurW-1:0] duration_ticks;
    logic            last;
  } seg_t;

  // International Morse table for A..Z and 0..9; space has an empty code
  function automatic code_t lookup_code(input logic [CharW-1:0] ch);
    code_t c;
    c.kind = KIND_MORSE;
    c.len  = '0;
    c.pat  = '0;
    case (ch)
      "A": {c.len, c.pat} = {3'd2, 5'b01000};
      "B": {c.len, c.pat} = {3'd4, 5'b10000};
      "C": {c.len, c.pat} = {3'd4, 5'b10100};
      "D": {c.len, c.pat} = {3'd3, 5'b10000};
      "E": {c.len, c.pat} = {3'd1, 5'b00000};
      "F": {c.len, c.pat} = {3'd4, 5'b00100};
      "G": {c.len, c.pat} = {3'd3, 5'b11000};
      "H": {c.len, c.pat} = {3'd4, 5'b00000};
      "I": {c.len, c.pat} = {3'd2, 5'b00000};
      "J": {c.len, c.pat} = {3'd4, 5'b01110};
      "K": {c.len, c.pat} = {3'd3, 5'b10100};
      "L": {c.len, c.pat} = {3'd4, 5'b01000};
      "M": {c.len, c.pat} = {3'd2, 5'b11000};
      "N": {c.len, c.pat} = {3'd2, 5'b10000};
      "O": {c.len, c.pat} = {3'd3, 5'b11100};
      "P": {c.len, c.pat} = {3'd4, 5'b01100};
      "Q": {c.len, c.pat} = {3'd4, 5'b11010};
      "R": {c.len, c.pat} = {3'd3, 5'b01000};
      "S": {c.len, c.pat} = {3'd3, 5'b00000};
      "T": {c.len, c.pat} = {3'd1, 5'b10000};
      "U": {c.len, c.pat} = {3'd3, 5'b00100};
      "V": {c.len, c.pat} = {3'd4, 5'b00010};
      "W": {c.len, c.pat} = {3'd3, 5'b01100};
      "X": {c.len, c.pat} = {3'd4, 5'b10010};
      "Y": {c.len, c.pat} = {3'd4, 5'b10110};
      "Z": {c.len, c.pat} = {3'd4, 5'b11000};
      "0": {c.len, c.pat} = {3'd5, 5'b11111};
      "1": {c.len, c.pat} = {3'd5, 5'b01111};
      "2": {c.len, c.pat} = {3'd5, 5'b00111};
      "3": {c.len, c.pat} = {3'd5, 5'b00011};
      "4": {c.len, c.pat} = {3'd5, 5'b00001};
      "5": {c.len, c.pat} = {3'd5, 5'b00000};
      "6": {c.len, c.pat} = {3'd5, 5'b10000};
      "7": {c.len, c.pat} = {3'd5, 5'b11000};
      "8": {c.len, c.pat} = {3'd5, 5'b11100};
      "9": {c.len, c.pat} = {3'd5, 5'b11110};
      " ": {c.len, c.pat} = {3'd0, 5'b00000};
      "/": c.kind = KIND_SLASH;
      default: c.kind = KIND_NONE;
    endcase
    return c;
  endfunction

endpackage

// File: hdl/mck_seg_gen.sv
// Character register and segment sequencer: one keying segment per cycle while seg_ready_i is high.
module mck_seg_gen (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [mck_pkg::CharW-1:0] char_code_i,
  input  logic [mck_pkg::DotW-1:0]  dot_ticks_i,
  output logic                      seg_valid_o,
  input  logic                      seg_ready_i,
  output mck_pkg::seg_t             seg_o
);
  import mck_pkg::*;

  typedef enum logic [1:0] {
    U_ONE,
    U_THREE,
    U_SEVEN
  } unit_e;

  logic            busy_q, busy_d;
  logic [SegW-1:0] seg_q, seg_d;
  code_t           code_q;
  code_t           code_in;
  logic            in_acc;
  logic            adv;
  logic            done;
  logic            is_end;
  logic [PatW-1:0] pat_shift;
  logic            dash;
  unit_e           units;
  logic [DurW-1:0] dot_ext;
  logic [DurW-1:0] dur_ticks;
  logic            seg_led;
  logic            seg_last;

  // Decode the incoming character
  assign code_in = lookup_code(char_code_i);

  // Handshake: take a new request when idle or while the final segment leaves
  assign adv        = busy_q && seg_ready_i;
  assign done       = adv && seg_last;
  assign in_stall_o = busy_q && !done;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Current segment: even steps before the end are symbols, odd steps the one-unit gaps, the end step the closing gap
  assign is_end    = (seg_q == {code_q.len, 1'b0});
  assign pat_shift = code_q.pat << seg_q[SegW-1:1];
  assign dash      = pat_shift[PatW-1];

  always_comb begin
    if (code_q.kind == KIND_SLASH) begin
      units = U_SEVEN;
    end else if (is_end) begin
      units = U_THREE;
    end else if (!seg_q[0] && dash) begin
      units = U_THREE;
    end else begin
      units = U_ONE;
    end
  end

  // Units times dot length by shift and add or subtract
  assign dot_ext = DurW'(dot_ticks_i);

  always_comb begin
    case (units)
      U_ONE:   dur_ticks = dot_ext;
      U_THREE: dur_ticks = (dot_ext << 1) + dot_ext;
      U_SEVEN: dur_ticks = (dot_ext << 3) - dot_ext;
      default: dur_ticks = dot_ext;
    endcase
  end

  assign seg_led     = (code_q.kind == KIND_MORSE) && !is_end && !seg_q[0];
  assign seg_last    = (code_q.kind == KIND_SLASH) || is_end;
  assign seg_o       = {seg_led, dur_ticks, seg_last};
  assign seg_valid_o = busy_q;

  // Next control state
  always_comb begin
    busy_d = busy_q;
    seg_d  = seg_q;
    if (in_acc) begin
      busy_d = (code_in.kind != KIND_NONE);
      seg_d  = '0;
    end else if (adv) begin
      if (seg_last) begin
        busy_d = 1'b0;
      end else begin
        seg_d = seg_q + SegW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      seg_q  <= '0;
    end else begin
      busy_q <= busy_d;
      seg_q  <= seg_d;
    end
  end

  // Character payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      code_q <= code_in;
    end
  end

  // The step count never runs past the closing gap
  a_seg_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && code_q.kind == KIND_MORSE |-> seg_q <= {code_q.len, 1'b0})
    else $error("segment step beyond closing gap");

  // A slash is a single segment
  a_slash_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && code_q.kind == KIND_SLASH |-> seg_q == '0)
    else $error("slash with more than one segment");

  // Finishing a character with no new request leaves the sequencer idle
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done && !in_acc |=> !busy_q)
    else $error("sequencer busy after final segment");

  // A segment that is not taken holds its step
  a_hold_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !seg_ready_i |=> busy_q && $stable(seg_q))
    else $error("segment step moved while stalled");

endmodule

// File: hdl/mck_out_reg.sv
// Output register for keying segments, loaded whenever it is empty or being taken.
module mck_out_reg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     seg_valid_i,
  output logic                     seg_ready_o,
  input  mck_pkg::seg_t            seg_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     led_on_o,
  output logic [mck_pkg::DurW-1:0] duration_ticks_o,
  output logic                     last_o
);
  import mck_pkg::*;

  logic  valid_q;
  seg_t  data_q;

  assign seg_ready_o = !valid_q || !out_stall_i;

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (seg_ready_o) begin
      valid_q <= seg_valid_i;
    end
  end

  // Segment payload
  always_ff @(posedge clk_i) begin
    if (seg_ready_o && seg_valid_i) begin
      data_q <= seg_i;
    end
  end

  assign out_valid_o      = valid_q;
  assign led_on_o         = data_q.led_on;
  assign duration_ticks_o = data_q.duration_ticks;
  assign last_o           = data_q.last;

endmodule

// File: hdl/morse_character_keyer_core.sv
// Morse keyer top level: dot-length register, segment sequencer, output register.
// The first segment passes the sequencer's character register and then the output register.
// Throughput: one segment per cycle while the output is not stalled; a Morse character of
//   n symbols keys 2n+1 segments (1 to 11), a slash 1, an unsupported code none.
// The sequencer takes the next character in the cycle its last segment leaves.
// Reset (async, active low): no segment pending, dot_ticks back to 1000.
module morse_character_keyer_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [mck_pkg::DotW-1:0]  cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [mck_pkg::CharW-1:0] char_code_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      led_on_o,
  output logic [mck_pkg::DurW-1:0]  duration_ticks_o,
  output logic                      last_o
);
  import mck_pkg::*;

  logic [DotW-1:0] dot_ticks_q;
  logic            seg_valid;
  logic            seg_ready;
  seg_t            seg;

  // Dot length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_ticks_q <= DOT_TICKS_RESET;
    end else if (cfg_we_i) begin
      dot_ticks_q <= cfg_wdata_i;
    end
  end

  mck_seg_gen u_seg_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .dot_ticks_i (dot_ticks_q),
    .seg_valid_o (seg_valid),
    .seg_ready_i (seg_ready),
    .seg_o       (seg)
  );

  mck_out_reg u_out_reg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .seg_valid_i      (seg_valid),
    .seg_ready_o      (seg_ready),
    .seg_i            (seg),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .led_on_o         (led_on_o),
    .duration_ticks_o (duration_ticks_o),
    .last_o           (last_o)
  );

endmodule

// File: sim/tb_top.sv
// Testbench for the Morse character keyer: directed and random characters checked per segment.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mck_pkg::*;

  localparam logic [CharW-1:0] SpaceChar = " ";
  localparam logic [CharW-1:0] SlashChar = "/";
  localparam byte DashSym = "-";

  localparam int unsigned DotUnits     = 1;
  localparam int unsigned DashUnits    = 3;
  localparam int unsigned SymGapUnits  = 1;
  localparam int unsigned CharGapUnits = 3;
  localparam int unsigned WordGapUnits = 7;

  localparam logic [DotW-1:0] UnitMax = {DotW{1'b1}};
  localparam int SettleCycles = 6;
  localparam int PhaseChars   = 42;
  localparam int MaxPrints    = 40;

  // Expected keying segments, predicted from each accepted character
  class KeyerScoreboard;
    logic [DotW-1:0] unit_ticks = DOT_TICKS_RESET;
    seg_t            segments[$];
    int              errors = 0;
    string letter_code[26] = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....",
                               "..", ".---", "-.-", ".-..", "--", "-.", "---", ".--.",
                               "--.-", ".-.", "...", "-", "..-", "...-", ".--", "-..-",
                               "-.--", "--.."};
    string digit_code[10] = '{"-----", ".----", "..---", "...--", "....-",
                              ".....", "-....", "--...", "---..", "----."};

    function void set_unit(input logic [DotW-1:0] v);
      unit_ticks = v;
    endfunction

    function int pending();
      return segments.size();
    endfunction

    function void push_segment(input logic led, input int unsigned units, input logic fin);
      seg_t s;
      longint unsigned prod;
      prod = longint'(units) * longint'(unit_ticks);
      s.led_on = led;
      s.duration_ticks = DurW'(prod);
      s.last = fin;
      segments.push_back(s);
    endfunction

    // Accepted character: queue the segments it keys
    function void note_char(input logic [CharW-1:0] c);
      string code;
      int k;
      if (c >= "A" && c <= "Z") code = letter_code[c - "A"];
      else if (c >= "0" && c <= "9") code = digit_code[c - "0"];
      else if (c == SpaceChar) code = "";
      else if (c == SlashChar) begin
        push_segment(1'b0, WordGapUnits, 1'b1);
        return;
      end else return;
      for (k = 0; k < code.len(); k++) begin
        push_segment(1'b1, (code[k] == DashSym) ? DashUnits : DotUnits, 1'b0);
        push_segment(1'b0, SymGapUnits, 1'b0);
      end
      push_segment(1'b0, CharGapUnits, 1'b1);
    endfunction

    task report_mismatch(input string msg);
      errors++;
      if (errors <= MaxPrints) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // Accepted segment: compare with the oldest expected one
    task check_segment(input seg_t got);
      seg_t want;
      if (segments.size() == 0) begin
        report_mismatch($sformatf("unexpected segment led=%0b dur=%0d last=%0b",
                                  got.led_on, got.duration_ticks, got.last));
        return;
      end
      want = segments.pop_front();
      if (got.led_on !== want.led_on)
        report_mismatch($sformatf("led_on %0b, want %0b", got.led_on, want.led_on));
      if (got.duration_ticks !== want.duration_ticks)
        report_mismatch($sformatf("duration_ticks %0d, want %0d",
                                  got.duration_ticks, want.duration_ticks));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
    endtask
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [DotW-1:0]  cfg_wdata_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [CharW-1:0] char_code_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic             led_on_o;
  logic [DurW-1:0]  duration_ticks_o;
  logic             last_o;

  KeyerScoreboard keyer_sb = new();
  int             send_idle_pct = 0;
  int             stall_pct = 0;
  seg_t           seen_seg;

  morse_character_keyer_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .char_code_i      (char_code_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .led_on_o         (led_on_o),
    .duration_ticks_o (duration_ticks_o),
    .last_o           (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Result side: check accepted segments, then pick next cycle's stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_seg.led_on = led_on_o;
      seen_seg.duration_ticks = duration_ticks_o;
      seen_seg.last = last_o;
      keyer_sb.check_segment(seen_seg);
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  function automatic bit is_keyed(input logic [CharW-1:0] c);
    return (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") ||
           c == SpaceChar || c == SlashChar;
  endfunction

  // Mostly letters and digits; some space, slash and raw byte noise
  function automatic logic [CharW-1:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 12) return CharW'($urandom_range(255));
    if (r < 17) return SpaceChar;
    if (r < 22) return SlashChar;
    if (r < 60) return CharW'("A" + $urandom_range(25));
    return CharW'("0" + $urandom_range(9));
  endfunction

  // One request on the character channel; valid stays up unless an idle gap follows
  task automatic send_char(input logic [CharW-1:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_code_i <= c;
    do @(posedge clk_i); while (in_stall_o);
    keyer_sb.note_char(c);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (keyer_sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_unit(input logic [DotW-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    keyer_sb.set_unit(v);
  endtask

  task automatic run_random(input int idle_pct, input int stall, input logic [DotW-1:0] unit);
    int keyed;
    logic [CharW-1:0] c;
    keyed = 0;
    write_unit(unit);
    send_idle_pct = idle_pct;
    stall_pct = stall;
    while (keyed < PhaseChars) begin
      c = pick_char();
      send_char(c);
      if (is_keyed(c)) keyed++;
    end
    drain();
  endtask

  initial begin
    logic [CharW-1:0] directed[$];
    directed = '{"A", "Z", "0", "9", "E", "T", "5", " ", "/", "a", 8'h00, 8'hFF,
                 8'h7F, 8'h80, "@", "[", ":"};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset unit, every kind of character, byte extremes
    foreach (directed[i]) send_char(directed[i]);
    drain();

    // Zero unit: segments still come, all of zero length
    write_unit('0);
    foreach (directed[i]) if (i < 9 && i > 5) send_char(directed[i]);
    send_char("0");
    drain();

    // Largest unit: longest dash and word gap
    write_unit(UnitMax);
    send_char("0");
    send_char("/");
    send_char(" ");
    send_char("H");
    drain();

    run_random(0, 0, DotW'(1));
    run_random(62, 0, DotW'($urandom_range(2, 24'hFFFFFE)));
    run_random(0, 62, UnitMax);
    run_random(11, 11, DotW'($urandom_range(1, 5000)));

    if (keyer_sb.errors == 0 && keyer_sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: morse_character_keyer_core.f
hdl/mck_pkg.sv
hdl/mck_seg_gen.sv
hdl/mck_out_reg.sv
hdl/morse_character_keyer_core.sv
sim/tb_top.sv
